@@ hw/rtl/blae_pkg.sv @@
// Shared types and constants for the bounded array list engine.
// Depends on nothing; every other file in hw/rtl imports it.
`default_nettype none

package blae_pkg;

  // Field widths of the item and result payloads.
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CNT_W  = 5;

  // The list never holds more slots than one dump can return.
  localparam int unsigned SLOTS_MAX     = 16;
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);
  localparam logic [CNT_W-1:0]     CAP_RESET    = CNT_W'(16);

  // Command codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND  = 3'd0,
    FN_INSERT  = 3'd1,
    FN_DELETE  = 3'd2,
    FN_SEARCH  = 3'd3,
    FN_REVERSE = 3'd4,
    FN_DUMP    = 3'd5
  } func_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SEARCH,
    ST_REV_RD_LO,
    ST_REV_RD_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_RESP
  } state_e;

  // One command item.
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] value;
  } item_t;

  // One result item.
  typedef struct packed {
    logic                     status;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_array_list_engine_core.sv @@
// Top level of the bounded array list engine: command sequencer around the slot memory.
// Depends on blae_pkg and instantiates blae_cfg for the capacity register.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_stall_o   item_t   (func, slot, value)
//   out       output     out_valid_o/out_stall_i result_t (status, position, word, count, last)
//   cfg       input      psel/penable/pwrite     capacity at byte address 0
//
// Per item, output stalls aside: append, insert at the tail, failed appends, inserts and
// deletes, unknown commands and reverse of fewer than two words go straight to the result;
// other inserts and deletes first move the words behind the slot, none for a delete of the
// last word; search reads slots until a match or the end; reverse swaps pairs; dump reads
// each usable slot, or gives a single result when no slot is usable.
// The pace is set by the single read port and single write port of the slot memory.
// Reset clears the fill count and sequencer at once; no clearing pass is needed.
// A stalled result holds in the output register; the next item is still taken.
`default_nettype none

module bounded_array_list_engine_core import blae_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // command items
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire item_t                 in_item_i,
  // result items
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output result_t                    out_item_o,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Only the slots a dump can show are ever filled.
  localparam int unsigned SLOTS = (DEPTH < SLOTS_MAX) ? DEPTH : SLOTS_MAX;
  localparam int unsigned IW    = $clog2(SLOTS);
  localparam logic [CNT_W-1:0] SlotsC = CNT_W'(SLOTS);
  localparam logic [IW:0]      TwoC   = (IW+1)'(2);

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] usable;

  state_e state_d, state_q;
  logic [CNT_W-1:0]  filled_d, filled_q;
  logic [CNT_W-1:0]  cnt_d, cnt_q;
  logic [IW-1:0]     ptr_d, ptr_q;
  logic [IW-1:0]     wr_addr_d, wr_addr_q;
  logic [IW-1:0]     tgt_d, tgt_q;
  logic [IW-1:0]     lo_d, lo_q;
  logic [IW-1:0]     hi_d, hi_q;
  logic              up_d, up_q;
  logic              pend_d, pend_q;
  logic [WORD_W-1:0] key_d, key_q;
  logic [WORD_W-1:0] tmp_d, tmp_q;
  logic              res_status_d, res_status_q;
  logic [POS_W-1:0]  res_pos_d, res_pos_q;

  logic              out_valid_d, out_valid_q;
  result_t           out_d, out_q;
  logic              out_load;
  logic              out_free;

  // Slot memory ports.
  logic [WORD_W-1:0] mem [SLOTS];
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] rdata_q;

  logic app_ok, ins_ok, ins_tail, del_ok, rev_ok;
  logic search_hit, search_end, rev_more, dump_last;

  // Capacity register.
  blae_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // Capacity clipped to the slots that exist.
  assign usable = (capacity > SlotsC) ? SlotsC : capacity;

  // Command checks and loop conditions.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign app_ok     = filled_q < usable;
  assign ins_ok     = (filled_q < usable) && ({1'b0, in_item_i.slot} < usable);
  assign ins_tail   = {1'b0, in_item_i.slot} >= filled_q;
  assign del_ok     = {1'b0, in_item_i.slot} < filled_q;
  assign rev_ok     = filled_q > CNT_W'(1);
  assign search_hit = pend_q && (rdata_q == key_q);
  assign search_end = !search_hit && (cnt_q >= filled_q);
  assign rev_more   = ({1'b0, lo_q} + TwoC) < {1'b0, hi_q};
  assign dump_last  = (cnt_q + CNT_W'(1)) == usable;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e'(in_item_i.func))
            FN_INSERT:  state_d = (ins_ok && !ins_tail) ? ST_SHIFT : ST_RESP;
            FN_DELETE:  state_d = del_ok ? ST_SHIFT : ST_RESP;
            FN_SEARCH:  state_d = ST_SEARCH;
            FN_REVERSE: state_d = rev_ok ? ST_REV_RD_LO : ST_RESP;
            FN_DUMP:    state_d = (usable != '0) ? ST_DUMP_RD : ST_RESP;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_SHIFT: begin
        if ((cnt_q == '0) && !pend_q) begin
          state_d = ST_RESP;
        end
      end
      ST_SEARCH: begin
        if (search_hit || search_end) begin
          state_d = ST_RESP;
        end
      end
      ST_REV_RD_LO: state_d = ST_REV_RD_HI;
      ST_REV_RD_HI: state_d = ST_REV_WR_LO;
      ST_REV_WR_LO: state_d = ST_REV_WR_HI;
      ST_REV_WR_HI: state_d = rev_more ? ST_REV_RD_HI : ST_RESP;
      ST_DUMP_RD:   state_d = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (out_free && dump_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control. Slots at or past the fill count are never read
  // for their contents: dump shows them as zero, so delete need not clear them.
  always_comb begin
    filled_d     = filled_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    wr_addr_d    = wr_addr_q;
    tgt_d        = tgt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    up_d         = up_q;
    pend_d       = pend_q;
    key_d        = key_q;
    tmp_d        = tmp_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    out_load     = 1'b0;
    out_d        = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d        = in_item_i.value;
          res_status_d = 1'b1;
          res_pos_d    = '0;
          pend_d       = 1'b0;
          cnt_d        = '0;
          unique case (func_e'(in_item_i.func))
            FN_APPEND: begin
              if (app_ok) begin
                mem_we       = 1'b1;
                mem_waddr    = IW'(filled_q);
                mem_wdata    = in_item_i.value;
                filled_d     = filled_q + CNT_W'(1);
                res_status_d = 1'b0;
              end
            end
            FN_INSERT: begin
              if (ins_ok) begin
                res_status_d = 1'b0;
                if (ins_tail) begin
                  mem_we    = 1'b1;
                  mem_waddr = IW'(filled_q);
                  mem_wdata = in_item_i.value;
                  filled_d  = filled_q + CNT_W'(1);
                end else begin
                  up_d  = 1'b0;
                  ptr_d = IW'(filled_q - CNT_W'(1));
                  cnt_d = filled_q - {1'b0, in_item_i.slot};
                  tgt_d = IW'(in_item_i.slot);
                end
              end
            end
            FN_DELETE: begin
              if (del_ok) begin
                res_status_d = 1'b0;
                up_d         = 1'b1;
                ptr_d        = IW'(in_item_i.slot) + IW'(1);
                cnt_d        = filled_q - {1'b0, in_item_i.slot} - CNT_W'(1);
              end
            end
            FN_SEARCH: begin
              res_status_d = 1'b1;
            end
            FN_REVERSE: begin
              res_status_d = 1'b0;
              lo_d         = '0;
              hi_d         = IW'(filled_q - CNT_W'(1));
            end
            FN_DUMP: begin
              res_status_d = 1'b1;
            end
            default: begin
              res_status_d = 1'b1;
            end
          endcase
        end
      end

      // Move one word a cycle: read one slot, write the word read last cycle.
      ST_SHIFT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = rdata_q;
        end
        if (cnt_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          ptr_d     = up_q ? ptr_q + IW'(1) : ptr_q - IW'(1);
          wr_addr_d = up_q ? ptr_q - IW'(1) : ptr_q + IW'(1);
          cnt_d     = cnt_q - CNT_W'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (up_q) begin
              filled_d = filled_q - CNT_W'(1);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = tgt_q;
              mem_wdata = key_q;
              filled_d  = filled_q + CNT_W'(1);
            end
          end
        end
      end

      // Read slots in order and compare each word in the cycle after its read.
      ST_SEARCH: begin
        if (search_hit) begin
          res_status_d = 1'b0;
          res_pos_d    = POS_W'(cnt_q - CNT_W'(1));
        end else if (cnt_q < filled_q) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(cnt_q);
          cnt_d     = cnt_q + CNT_W'(1);
          pend_d    = 1'b1;
        end
      end

      // Swap one pair: read low, read high, write low, write high.
      ST_REV_RD_LO: begin
        mem_re    = 1'b1;
        mem_raddr = lo_q;
      end
      ST_REV_RD_HI: begin
        mem_re    = 1'b1;
        mem_raddr = hi_q;
        tmp_d     = rdata_q;
      end
      ST_REV_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = rdata_q;
      end
      ST_REV_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = tmp_q;
        if (rev_more) begin
          lo_d      = lo_q + IW'(1);
          hi_d      = hi_q - IW'(1);
          mem_re    = 1'b1;
          mem_raddr = lo_q + IW'(1);
        end
      end

      // Dump: one slot per item, next read issued as each item is loaded.
      ST_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = IW'(cnt_q);
      end
      ST_DUMP_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.status   = 1'b0;
          out_d.position = POS_W'(cnt_q);
          out_d.word     = (cnt_q < filled_q) ? rdata_q : '0;
          out_d.count    = filled_q;
          out_d.last     = dump_last;
          if (!dump_last) begin
            cnt_d     = cnt_q + CNT_W'(1);
            mem_re    = 1'b1;
            mem_raddr = IW'(cnt_q + CNT_W'(1));
          end
        end
      end

      // Single result of every other command.
      ST_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.status   = res_status_q;
          out_d.position = res_pos_q;
          out_d.word     = '0;
          out_d.count    = filled_q;
          out_d.last     = 1'b1;
        end
      end

      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Output register valid.
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      filled_q    <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      up_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      up_q        <= up_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    wr_addr_q    <= wr_addr_d;
    tgt_q        <= tgt_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    tmp_q        <= tmp_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_q        <= out_d;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The fill count never exceeds the slots that exist.
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= SlotsC)
    else $error("fill count beyond slot count");

  // Overlapped read and write never touch the same slot.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same slot in one cycle");

  // A result is loaded only when the output register can take it.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a waiting result");

  // The fill count only changes on the way to a single result.
  a_filled_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q != $past(filled_q)) |-> (state_q == ST_RESP))
    else $error("fill count changed outside a command's end");

  // A dump item that is not the last keeps the dump going.
  a_dump_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_d.last) |=> (state_q == ST_DUMP_OUT))
    else $error("dump ended early");

endmodule

`default_nettype wire

@@ hw/rtl/blae_cfg.sv @@
// Configuration register block: holds the capacity register behind an APB-style port.
// Depends on blae_pkg for the address map and reset value.
`default_nettype none

module blae_cfg import blae_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [CNT_W-1:0]      capacity_o
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [CNT_W-1:0]     capacity_d, capacity_q;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register decode; writes to unmapped addresses are dropped.
  always_comb begin
    capacity_d = capacity_q;
    if (wr_en && (reg_idx == REG_CAPACITY)) begin
      capacity_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      prdata = {{(APB_DATA_W-CNT_W){1'b0}}, capacity_q};
    end
  end

  assign capacity_o = capacity_q;

endmodule

`default_nettype wire

@@ bench/tb_bounded_array_list_engine_core.sv @@
// Self-checking testbench for the bounded array list engine core.
// Depends on blae_pkg and bounded_array_list_engine_core; each result item is checked
// against a shadow copy of the list that is updated as command items are accepted.
`default_nettype none

module tb_bounded_array_list_engine_core;
  import blae_pkg::*;

  localparam int unsigned LIST_DEPTH    = DEPTH_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned ITEMS_PER_CAP = 26;

  // Command codes that the block must refuse.
  localparam logic [FUNC_W-1:0] FN_UNDEF_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNDEF_7 = 3'd7;

  // One row of the directed plan: a capacity write or a command item.
  typedef struct {
    bit               is_cfg;
    item_t            cmd;
    bit               typed;
    result_t          want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  item_t                 in_item    = '0;
  logic                  out_stall  = 1'b0;
  logic                  apb_sel    = 1'b0;
  logic                  apb_enable = 1'b0;
  logic                  apb_write  = 1'b0;
  logic [APB_ADDR_W-1:0] apb_addr   = '0;
  logic [APB_DATA_W-1:0] apb_wdata  = '0;

  wire logic                  in_stall_o;
  wire logic                  out_valid_o;
  result_t                    out_item_o;
  wire logic [APB_DATA_W-1:0] prdata;
  wire logic                  pready;

  // Shadow of the list and of the capacity register.
  logic [WORD_W-1:0] list_words [SLOTS_MAX];
  logic [CNT_W-1:0]  list_fill;
  logic [CNT_W-1:0]  list_cap;

  result_t   cmd_results [$];
  result_t   due_results [$];
  plan_row_t plan [$];

  bit          steady     = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned res_seen   = 0;

  bounded_array_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .psel        (apb_sel),
    .penable     (apb_enable),
    .pwrite      (apb_write),
    .paddr       (apb_addr),
    .pwdata      (apb_wdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous limit, well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 50)
      $display("mismatch on result %0d: %s got %h expected %h", res_seen, what, got, want);
    mismatches++;
  endtask

  function automatic void note_result(input bit st, input int unsigned pos,
                                      input logic [WORD_W-1:0] w, input bit fin);
    result_t r;
    r.status   = st;
    r.position = POS_W'(pos);
    r.word     = w;
    r.count    = list_fill;
    r.last     = fin;
    cmd_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow list and queue the results it causes.
  function automatic void apply_list_cmd(input item_t cmd);
    int unsigned       lim;
    int unsigned       lo;
    int unsigned       hi;
    logic [WORD_W-1:0] tmp;
    bit                hit;
    lim = list_cap;
    if (lim > LIST_DEPTH) lim = LIST_DEPTH;
    if (lim > SLOTS_MAX) lim = SLOTS_MAX;
    hit = 1'b0;
    case (cmd.func)
      FN_APPEND: begin
        if (list_fill >= lim) begin
          note_result(1'b1, 0, '0, 1'b1);
        end else begin
          list_words[list_fill] = cmd.value;
          list_fill++;
          note_result(1'b0, 0, '0, 1'b1);
        end
      end
      FN_INSERT: begin
        if (list_fill >= lim || cmd.slot >= lim) begin
          note_result(1'b1, 0, '0, 1'b1);
        end else begin
          if (cmd.slot >= list_fill) begin
            list_words[list_fill] = cmd.value;
          end else begin
            for (int k = list_fill; k > cmd.slot; k--) list_words[k] = list_words[k-1];
            list_words[cmd.slot] = cmd.value;
          end
          list_fill++;
          note_result(1'b0, 0, '0, 1'b1);
        end
      end
      FN_DELETE: begin
        if (cmd.slot >= list_fill) begin
          note_result(1'b1, 0, '0, 1'b1);
        end else begin
          for (int k = cmd.slot; k + 1 < list_fill; k++) list_words[k] = list_words[k+1];
          list_words[list_fill-1] = '0;
          list_fill--;
          note_result(1'b0, 0, '0, 1'b1);
        end
      end
      FN_SEARCH: begin
        for (int k = 0; k < list_fill; k++) begin
          if (!hit && list_words[k] == cmd.value) begin
            note_result(1'b0, k, '0, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) note_result(1'b1, 0, '0, 1'b1);
      end
      FN_REVERSE: begin
        if (list_fill > 1) begin
          lo = 0;
          hi = list_fill - 1;
          while (lo < hi) begin
            tmp            = list_words[lo];
            list_words[lo] = list_words[hi];
            list_words[hi] = tmp;
            lo++;
            hi--;
          end
        end
        note_result(1'b0, 0, '0, 1'b1);
      end
      FN_DUMP: begin
        if (lim == 0) begin
          note_result(1'b1, 0, '0, 1'b1);
        end else begin
          for (int k = 0; k < lim; k++) note_result(1'b0, k, list_words[k], k + 1 == lim);
        end
      end
      default: note_result(1'b1, 0, '0, 1'b1);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Mix of extremes, small values that repeat, and wide random words.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed commands aimed at the filled part, with some noise.
  function automatic item_t rand_item();
    item_t       it;
    int unsigned r;
    int unsigned top;
    r        = $urandom_range(0, 99);
    it.value = pick_word();
    if (r < 25)      it.func = FN_APPEND;
    else if (r < 45) it.func = FN_INSERT;
    else if (r < 65) it.func = FN_DELETE;
    else if (r < 80) it.func = FN_SEARCH;
    else if (r < 87) it.func = FN_REVERSE;
    else if (r < 95) it.func = FN_DUMP;
    else             it.func = r[0] ? FN_UNDEF_6 : FN_UNDEF_7;
    top = (list_fill > 15) ? 15 : list_fill;
    if ($urandom_range(0, 3) == 0) it.slot = SLOT_W'($urandom_range(0, 15));
    else                           it.slot = SLOT_W'($urandom_range(0, top));
    if (it.func == FN_SEARCH && list_fill > 0 && $urandom_range(0, 9) < 7)
      it.value = list_words[$urandom_range(0, list_fill - 1)];
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record what it should produce.
  task automatic send_item(input item_t cmd, input bit typed, input result_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    apply_list_cmd(cmd);
    if (typed) begin
      cmd_results.delete();
      due_results.push_back(want);
    end else begin
      while (cmd_results.size() != 0) due_results.push_back(cmd_results.pop_front());
    end
  endtask

  // Stop offering items and wait until the block has delivered everything.
  task automatic drain_list();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the capacity register while idle, then read it back.
  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    drain_list();
    apb_addr   <= APB_ADDR_W'({REG_CAPACITY, 2'b00});
    apb_wdata  <= APB_DATA_W'(cap);
    apb_write  <= 1'b1;
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    list_cap = cap;
    apb_write  <= 1'b0;
    apb_enable <= 1'b0;
    @(posedge clk_i);
    apb_enable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(cap))
      flag_mismatch("capacity readback", 64'(prdata), 64'(cap));
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
  endtask

  function automatic void add_cap(input logic [CNT_W-1:0] cap);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.cmd.value = WORD_W'(cap);
    plan.push_back(row);
  endfunction

  function automatic void add_op(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] sl,
                                 input logic [WORD_W-1:0] v);
    plan_row_t row;
    row           = '{default: '0};
    row.cmd.func  = fn;
    row.cmd.slot  = sl;
    row.cmd.value = v;
    plan.push_back(row);
  endfunction

  // A single-result command whose outcome is written out in the row.
  function automatic void add_chk(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] sl,
                                  input logic [WORD_W-1:0] v, input bit st,
                                  input logic [POS_W-1:0] pos, input logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row               = '{default: '0};
    row.cmd.func      = fn;
    row.cmd.slot      = sl;
    row.cmd.value     = v;
    row.typed         = 1'b1;
    row.want.status   = st;
    row.want.position = pos;
    row.want.count    = cnt;
    row.want.last     = 1'b1;
    plan.push_back(row);
  endfunction

  // Output side stalls in runs of random length, with some long ones.
  always @(posedge clk_i) begin : stall_gen
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else if (r < 55) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else if (r < 90) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(4, 30);
    end
  end

  // Every accepted result item is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result with none pending", 64'(out_item_o), 64'(0));
      end else begin
        want = due_results.pop_front();
        if (out_item_o.status !== want.status)
          flag_mismatch("status", 64'(out_item_o.status), 64'(want.status));
        if (out_item_o.position !== want.position)
          flag_mismatch("position", 64'(out_item_o.position), 64'(want.position));
        if (out_item_o.word !== want.word)
          flag_mismatch("word", 64'(out_item_o.word), 64'(want.word));
        if (out_item_o.count !== want.count)
          flag_mismatch("count", 64'(out_item_o.count), 64'(want.count));
        if (out_item_o.last !== want.last)
          flag_mismatch("last", 64'(out_item_o.last), 64'(want.last));
      end
      res_seen++;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] caps [7];
    for (int k = 0; k < SLOTS_MAX; k++) list_words[k] = '0;
    list_fill = '0;
    list_cap  = CAP_RESET;

    // Directed plan: empty list, extremes, every command, then capacity corners.
    add_chk(FN_DELETE, 4'd0, 32'h0, 1'b1, 4'd0, 5'd0);
    add_chk(FN_SEARCH, 4'd0, 32'h0, 1'b1, 4'd0, 5'd0);
    add_chk(FN_REVERSE, 4'd0, 32'h0, 1'b0, 4'd0, 5'd0);
    add_chk(FN_APPEND, 4'd0, 32'h7FFF_FFFF, 1'b0, 4'd0, 5'd1);
    add_chk(FN_APPEND, 4'd0, 32'h8000_0000, 1'b0, 4'd0, 5'd2);
    add_chk(FN_INSERT, 4'd0, 32'hFFFF_FFFF, 1'b0, 4'd0, 5'd3);
    add_chk(FN_INSERT, 4'd15, 32'h0, 1'b0, 4'd0, 5'd4);
    add_chk(FN_INSERT, 4'd2, 32'h5A5A_5A5A, 1'b0, 4'd0, 5'd5);
    add_chk(FN_SEARCH, 4'd0, 32'h8000_0000, 1'b0, 4'd3, 5'd5);
    add_chk(FN_SEARCH, 4'd0, 32'h1234_5678, 1'b1, 4'd0, 5'd5);
    add_chk(FN_REVERSE, 4'd0, 32'h0, 1'b0, 4'd0, 5'd5);
    add_op(FN_DUMP, 4'd0, 32'h0);
    add_chk(FN_DELETE, 4'd15, 32'h0, 1'b1, 4'd0, 5'd5);
    add_chk(FN_DELETE, 4'd0, 32'h0, 1'b0, 4'd0, 5'd4);
    add_chk(FN_DELETE, 4'd3, 32'h0, 1'b0, 4'd0, 5'd3);
    add_chk(FN_UNDEF_6, 4'd0, 32'h0, 1'b1, 4'd0, 5'd3);
    add_chk(FN_UNDEF_7, 4'd15, 32'hFFFF_FFFF, 1'b1, 4'd0, 5'd3);
    add_chk(FN_INSERT, 4'd1, 32'hA5A5_A5A5, 1'b0, 4'd0, 5'd4);
    add_chk(FN_SEARCH, 4'd0, 32'h7FFF_FFFF, 1'b0, 4'd3, 5'd4);
    add_op(FN_DUMP, 4'd0, 32'h0);
    // No usable slots: growth fails, dump gives a single failing result.
    add_cap(5'd0);
    add_chk(FN_APPEND, 4'd0, 32'h1, 1'b1, 4'd0, 5'd4);
    add_chk(FN_DUMP, 4'd0, 32'h0, 1'b1, 4'd0, 5'd4);
    add_op(FN_DELETE, 4'd0, 32'h0);
    // Capacity below the fill count.
    add_cap(5'd2);
    add_chk(FN_INSERT, 4'd0, 32'h2, 1'b1, 4'd0, 5'd3);
    add_op(FN_DUMP, 4'd0, 32'h0);
    // Capacity above the store size is clipped.
    add_cap(5'd31);
    add_op(FN_APPEND, 4'd0, 32'h3);

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_capacity(plan[i].cmd.value[CNT_W-1:0]);
      else                send_item(plan[i].cmd, plan[i].typed, plan[i].want);
    end

    // Random part: one capacity setting per phase, one phase without idling.
    caps = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd16, 5'd9};
    caps[6] = CNT_W'($urandom_range(2, 15));
    for (int ph = 0; ph < 7; ph++) begin
      set_capacity(caps[ph]);
      steady <= (ph == 5);
      repeat (ITEMS_PER_CAP) send_item(rand_item(), 1'b0, '0);
    end
    steady <= 1'b0;
    drain_list();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
